[rtl/bitmap_page_allocator_core_defines.svh]
// ----------------------------------------------------------------------------
// Bitmap page allocator: assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, opcodes, control/status bundles and bit-scan helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGES_DEF  = 65536;
    localparam int WORD_W     = 16;   // bitmap bits per memory word
    localparam int PAGE_SHIFT = 12;   // 4 KiB pages
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 28;
    localparam int CNT_W      = 17;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_USABLE  = 2'd2,
        OP_RESERVE = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item, arm scan
        logic scan_step;  // issue next scan read, evaluate returned word
        logic set_fail;
        logic rinit;      // compute range bounds from r_first/r_count
        logic rmw_rd;
        logic rmw_wr;
        logic clr_wr;     // start-up fill of the bitmap
        logic cnt_upd;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic cnt_zero;
        logic scan_hit;
        logic scan_end;
        logic rng_empty;
        logic rng_last;
        logic out_free;
    } t_stat;

    // Number of consecutive ones from bit 15 downward.
    function automatic logic [4:0] lead_ones16(input logic [15:0] v);
        logic [15:0] s;
        logic [4:0]  n;
        s = v;
        n = '0;
        if (s == 16'hFFFF) begin
            n = 5'd16;
        end else begin
            if (s[15:8] == 8'hFF) begin
                n = n + 5'd8;
                s = s << 8;
            end
            if (s[15:12] == 4'hF) begin
                n = n + 5'd4;
                s = s << 4;
            end
            if (s[15:14] == 2'b11) begin
                n = n + 5'd2;
                s = s << 2;
            end
            if (s[15]) begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // Index of the lowest set bit (v assumed nonzero).
    function automatic logic [3:0] low_index16(input logic [15:0] v);
        logic [15:0] s;
        logic [3:0]  n;
        s = v;
        n = '0;
        if (s[7:0] == 8'h00) begin
            n = n + 4'd8;
            s = s >> 8;
        end
        if (s[3:0] == 4'h0) begin
            n = n + 4'd4;
            s = s >> 4;
        end
        if (s[1:0] == 2'b00) begin
            n = n + 4'd2;
            s = s >> 2;
        end
        if (!s[0]) begin
            n = n + 4'd1;
        end
        return n;
    endfunction

endpackage

[rtl/bitmap_page_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit allocator over a one-bit-per-page used map with page counters.
// ----------------------------------------------------------------------------
// Usage:
//   One request item on the s_axis side, one result item on the m_axis side.
//   Requests: allocate (first-fit run of page_count free pages), free,
//   mark usable, reserve. Results carry the base address of an allocated
//   run, a fail flag and the free/used page counters after the request.
// Operation (W = 16 map bits per memory word, D = ceil(PAGES/16) words):
//   Requests are processed one at a time; s_axis_tready is high only idle.
//   Allocate: scan words up to the hit, then a read and a write per word
//   marked; a full miss scans all D words (4096 at the default size).
//   Free / mark usable / reserve: one read and one write of the
//   single-port bitmap memory per word touched.
//   The bitmap memory port is what paces the scan and the range update.
// Reset: the map is filled with all-used words, one word a cycle, over
//   all D words (4096 by default); no request is taken during that pass.
//   Both counters reset to zero.
// Stall: the result sits in an output register; one more request may be
//   taken and run meanwhile, and it then waits for that register to drain.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
    parameter int PAGES = bpa_pkg::PAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // base_address[27:0], page_count[44:28]
    input  logic [bpa_pkg::OP_W-1:0]        s_axis_tuser,  // operation[1:0]
    // result
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // result_address[27:0],
                                                           // free_total[44:28], used_total[61:45]
    output logic                            m_axis_tuser   // fail
);

    localparam int AW = bpa_pkg::ADDR_W;
    localparam int CN = bpa_pkg::CNT_W;

    bpa_pkg::t_cmd  cmd;
    bpa_pkg::t_stat stat;

    logic          out_valid;
    logic [AW-1:0] out_addr;
    logic          out_fail;
    logic [CN-1:0] out_free;
    logic [CN-1:0] out_used;

    // sequencing
    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // map memory, scan, counters, result register
    bpa_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (s_axis_tuser),
        .i_base      (s_axis_tdata[AW-1:0]),
        .i_count     (s_axis_tdata[AW +: CN]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (out_valid),
        .o_out_addr  (out_addr),
        .o_out_fail  (out_fail),
        .o_out_free  (out_free),
        .o_out_used  (out_used)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_fail;
    assign m_axis_tdata  = {{(bpa_pkg::OUT_DATA_W - AW - 2 * CN){1'b0}},
                            out_used, out_free, out_addr};

endmodule

[rtl/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences start-up fill, first-fit scan, range update and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bpa_pkg::t_stat i_stat,
    output bpa_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_RINIT,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (i_stat.is_alloc && i_stat.cnt_zero) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_FIN;
                end else if (i_stat.is_alloc) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_RINIT;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_stat.scan_hit) begin
                    n_state = ST_RINIT;
                end else if (i_stat.scan_end) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_FIN;
                end
            end
            ST_RINIT: begin
                o_cmd.rinit = 1'b1;
                n_state     = ST_RD;
            end
            ST_RD: begin
                if (i_stat.rng_empty) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rmw_rd = 1'b1;
                    n_state      = ST_WR;
                end
            end
            ST_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_state      = i_stat.rng_last ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                o_cmd.cnt_upd = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/bpa_dp.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Bitmap memory, word-wide first-fit scan, range read-modify-write, counters.
// ----------------------------------------------------------------------------
module bpa_dp #(
    parameter int PAGES = bpa_pkg::PAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpa_pkg::t_cmd              i_cmd,
    output bpa_pkg::t_stat             o_stat,
    input  logic [bpa_pkg::OP_W-1:0]   i_op,
    input  logic [bpa_pkg::ADDR_W-1:0] i_base,
    input  logic [bpa_pkg::CNT_W-1:0]  i_count,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [bpa_pkg::ADDR_W-1:0] o_out_addr,
    output logic                       o_out_fail,
    output logic [bpa_pkg::CNT_W-1:0]  o_out_free,
    output logic [bpa_pkg::CNT_W-1:0]  o_out_used
);

    localparam int WORD_W    = bpa_pkg::WORD_W;
    localparam int WB        = $clog2(WORD_W);
    localparam int DEPTH     = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WAW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW        = WAW + WB;
    localparam int CW        = $clog2(PAGES + 1);
    localparam int SW0       = (CW > 18) ? CW : 18;
    localparam int SW        = (PW + 1 > SW0) ? PW + 1 : SW0;
    localparam int LAST_BITS = PAGES - (DEPTH - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [WAW-1:0]    LAST_WORD = WAW'(DEPTH - 1);

    // bitmap: 1 = page used
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // item
    bpa_pkg::t_op              r_op;
    logic [bpa_pkg::CNT_W-1:0] r_count;
    logic [SW-1:0]             r_first;
    logic [SW-1:0]             r_end;
    logic [WAW-1:0]            r_lw;
    logic [WB-1:0]             r_lbit;
    logic                      r_fail;

    // walk / scan
    logic [WAW-1:0] r_word;
    logic [WAW-1:0] r_scan_addr;
    logic [WAW-1:0] r_dword;
    logic           r_scan_more;
    logic           r_pend;
    logic [CW-1:0]  r_run;

    // counters and result register
    logic [CW-1:0]              r_free;
    logic [CW-1:0]              r_used;
    logic                       r_out_valid;
    logic [bpa_pkg::ADDR_W-1:0] r_out_addr;
    logic                       r_out_fail;
    logic [bpa_pkg::CNT_W-1:0]  r_out_free;
    logic [bpa_pkg::CNT_W-1:0]  r_out_used;

    // ---------------- scan evaluation of the returned word ----------------
    logic [WORD_W-1:0] vmask;
    logic [WORD_W-1:0] free_vec;
    logic [WORD_W-1:0] hit_vec;
    logic [4:0]        lead    [WORD_W];
    logic [SW-1:0]     run_len [WORD_W];
    logic [WB-1:0]     hit_sel;
    logic [SW-1:0]     hit_start;
    logic              any_hit;

    always_comb begin
        vmask    = (r_dword == LAST_WORD) ? LAST_MASK : '1;
        free_vec = ~r_rdata & vmask;
        for (int j = 0; j < WORD_W; j++) begin
            // free run ending at bit j; spills into the carried run when whole prefix is free
            lead[j]    = bpa_pkg::lead_ones16(free_vec << (WORD_W - 1 - j));
            run_len[j] = (lead[j] == 5'(j + 1)) ? SW'(r_run) + SW'(j + 1) : SW'(lead[j]);
            hit_vec[j] = (run_len[j] >= SW'(r_count));
        end
        any_hit   = |hit_vec;
        hit_sel   = bpa_pkg::low_index16(hit_vec);
        hit_start = SW'({r_dword, hit_sel}) + SW'(1) - SW'(r_count);
    end

    // ---------------- range bounds and word mask ----------------
    logic [SW-1:0]     end_raw;
    logic [SW-1:0]     end_clip;
    logic [SW-1:0]     end_m1;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] rmw_data;
    logic              set_mode;
    logic              rng_empty;

    always_comb begin
        end_raw   = r_first + SW'(r_count);
        end_clip  = (end_raw > SW'(PAGES)) ? SW'(PAGES) : end_raw;
        end_m1    = end_clip - SW'(1);
        lo_mask   = (r_word == r_first[WB +: WAW]) ? ({WORD_W{1'b1}} << r_first[WB-1:0]) : '1;
        hi_mask   = (r_word == r_lw) ? ({WORD_W{1'b1}} >> (WB'(WORD_W - 1) - r_lbit)) : '1;
        set_mode  = (r_op == bpa_pkg::OP_ALLOC) || (r_op == bpa_pkg::OP_RESERVE);
        rmw_data  = set_mode ? (r_rdata | (lo_mask & hi_mask))
                             : (r_rdata & ~(lo_mask & hi_mask));
        rng_empty = (r_first >= r_end);
    end

    // ---------------- counter arithmetic ----------------
    logic [SW-1:0] npg;
    logic [SW:0]   free_sum;
    logic [SW:0]   used_sum;
    logic [CW-1:0] free_up;
    logic [CW-1:0] free_dn;
    logic [CW-1:0] used_up;
    logic [CW-1:0] used_dn;

    always_comb begin
        npg      = rng_empty ? '0 : (r_end - r_first);
        free_sum = (SW + 1)'(r_free) + (SW + 1)'(npg);
        used_sum = (SW + 1)'(r_used) + (SW + 1)'(npg);
        free_up  = (free_sum > (SW + 1)'(PAGES)) ? CW'(PAGES) : CW'(free_sum);
        used_up  = (used_sum > (SW + 1)'(PAGES)) ? CW'(PAGES) : CW'(used_sum);
        free_dn  = (SW'(r_free) > npg) ? CW'(SW'(r_free) - npg) : '0;
        used_dn  = (SW'(r_used) > npg) ? CW'(SW'(r_used) - npg) : '0;
    end

    // ---------------- memory ----------------
    logic           rd_en;
    logic [WAW-1:0] rd_addr;

    assign rd_en   = i_cmd.rmw_rd || (i_cmd.scan_step && r_scan_more);
    assign rd_addr = i_cmd.rmw_rd ? r_word : r_scan_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_word] <= '1;
        end else if (i_cmd.rmw_wr) begin
            mem[r_word] <= rmw_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_scan_addr <= '0;
            r_scan_more <= 1'b0;
            r_pend      <= 1'b0;
            r_run       <= '0;
            r_fail      <= 1'b0;
            r_free      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr || i_cmd.rmw_wr) begin
                r_word <= r_word + WAW'(1);
            end else if (i_cmd.rinit) begin
                r_word <= r_first[WB +: WAW];
            end

            if (i_cmd.load) begin
                r_scan_addr <= '0;
                r_scan_more <= 1'b1;
                r_pend      <= 1'b0;
                r_run       <= '0;
                r_fail      <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= r_scan_more;
                if (r_scan_more) begin
                    r_scan_more <= (r_scan_addr != LAST_WORD);
                    r_scan_addr <= r_scan_addr + WAW'(1);
                end
                if (r_pend) begin
                    r_run <= CW'(run_len[WORD_W-1]);
                end
            end
            if (i_cmd.set_fail) begin
                r_fail <= 1'b1;
            end

            if (i_cmd.cnt_upd && !r_fail) begin
                unique case (r_op)
                    bpa_pkg::OP_FREE: begin
                        r_free <= free_up;
                        r_used <= used_dn;
                    end
                    bpa_pkg::OP_USABLE: begin
                        r_free <= free_up;
                    end
                    bpa_pkg::OP_ALLOC, bpa_pkg::OP_RESERVE: begin
                        r_free <= free_dn;
                        r_used <= used_up;
                    end
                    default: begin
                        r_free <= r_free;
                    end
                endcase
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= bpa_pkg::t_op'(i_op);
            r_count <= i_count;
            r_first <= SW'(i_base[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT]);
        end else if (i_cmd.scan_step && r_pend && any_hit) begin
            r_first <= hit_start;
        end
        if (r_pend) begin
            r_dword <= r_dword;
        end
        if (rd_en) begin
            r_dword <= rd_addr;
        end
        if (i_cmd.rinit) begin
            r_end  <= end_clip;
            r_lw   <= end_m1[WB +: WAW];
            r_lbit <= end_m1[WB-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_addr <= ((r_op == bpa_pkg::OP_ALLOC) && !r_fail)
                        ? bpa_pkg::ADDR_W'({r_first, {bpa_pkg::PAGE_SHIFT{1'b0}}}) : '0;
            r_out_fail <= r_fail;
            r_out_free <= bpa_pkg::CNT_W'(r_free);
            r_out_used <= bpa_pkg::CNT_W'(r_used);
        end
    end

    // ---------------- status ----------------
    always_comb begin
        o_stat.clr_last  = (r_word == LAST_WORD);
        o_stat.is_alloc  = (r_op == bpa_pkg::OP_ALLOC);
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.scan_hit  = r_pend && any_hit;
        o_stat.scan_end  = r_pend && !any_hit && (r_dword == LAST_WORD);
        o_stat.rng_empty = rng_empty;
        o_stat.rng_last  = (r_word == r_lw);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_addr  = r_out_addr;
    assign o_out_fail  = r_out_fail;
    assign o_out_free  = r_out_free;
    assign o_out_used  = r_out_used;

endmodule

[rtl/bpa_checker.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator port checker
// Port-level assertions, bound onto the core.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_core_defines.svh"

module bpa_checker #(
    parameter int PAGES = bpa_pkg::PAGES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    // a stalled result holds
    `BPA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // one request in flight: no back-to-back accept
    `BPA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

    // a failed allocation reports address zero
    `BPA_ASSERT_IMP(a_fail_addr, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[27:0] == 28'd0, "fail with nonzero address")

    // counters never pass the page total
    `BPA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, m_axis_tvalid, (32'(m_axis_tdata[44:28]) <= PAGES) && (32'(m_axis_tdata[61:45]) <= PAGES), "counter above page total")

endmodule

bind bitmap_page_allocator_core bpa_checker #(
    .PAGES (PAGES)
) u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/tb_bitmap_page_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Drives request items (allocate, free, mark usable, reserve) with random
// gaps and checks every result item against a bit-level shadow of the
// page map and the two page counters.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = bpa_pkg::ADDR_W;
    localparam int CNT_W       = bpa_pkg::CNT_W;
    localparam int OP_W        = bpa_pkg::OP_W;
    localparam int IN_DATA_W   = bpa_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = bpa_pkg::OUT_DATA_W;
    localparam int PAGE_SHIFT  = bpa_pkg::PAGE_SHIFT;
    localparam int MAP_PAGES   = bpa_pkg::PAGES_DEF;
    localparam int POOL_PAGES  = 2048;    // low region used by most random items
    localparam int RAND_ITEMS  = 118;
    localparam int STALL_LIMIT = 50000;   // cycles with no item moving on either side

    typedef struct {
        bpa_pkg::t_op       op;
        logic [ADDR_W-1:0]  base;
        logic [CNT_W-1:0]   count;
    } t_page_req;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic               fail;
        logic [CNT_W-1:0]   free_total;
        logic [CNT_W-1:0]   used_total;
    } t_page_result;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   m_tready = 1'b0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;

    bitmap_page_allocator_core #(
        .PAGES(MAP_PAGES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the allocator state.
    bit           page_used [MAP_PAGES];
    int unsigned  free_cnt;
    int unsigned  used_cnt;

    t_page_req    pending_requests[$];
    t_page_result expected_results[$];
    int           total_requests = 0;
    int           req_accepted   = 0;
    int           results_seen   = 0;
    int           mismatches     = 0;
    int           hold_left      = 0;

    // Apply one request to the shadow state and return the result it causes.
    function automatic t_page_result predict_page_op(input logic [IN_DATA_W-1:0] d,
                                                     input logic [OP_W-1:0] u);
        t_page_result res;
        bpa_pkg::t_op op;
        int unsigned  first;
        int unsigned  cnt;
        int unsigned  last_p;
        int unsigned  run;
        int unsigned  start;
        bit           found;
        op     = bpa_pkg::t_op'(u);
        first  = 32'(d[ADDR_W-1:0] >> PAGE_SHIFT);
        cnt    = 32'(d[ADDR_W +: CNT_W]);
        res.addr = '0;
        res.fail = 1'b0;
        if (op == bpa_pkg::OP_ALLOC) begin
            run   = 0;
            start = 0;
            found = 1'b0;
            // first fit from page 0; a used page restarts the run
            if (cnt != 0) begin
                for (int unsigned p = 0; p < MAP_PAGES && !found; p++) begin
                    if (page_used[p]) begin
                        run = 0;
                    end else begin
                        if (run == 0) start = p;
                        run++;
                        if (run == cnt) found = 1'b1;
                    end
                end
            end
            if (found) begin
                for (int unsigned p = start; p < start + cnt; p++) begin
                    page_used[p] = 1'b1;
                    if (used_cnt < MAP_PAGES) used_cnt++;
                    if (free_cnt > 0) free_cnt--;
                end
                res.addr = ADDR_W'(start << PAGE_SHIFT);
            end else begin
                res.fail = 1'b1;
            end
        end else begin
            // pages at or past the end of the map are dropped
            last_p = first + cnt;
            if (last_p > MAP_PAGES) last_p = MAP_PAGES;
            for (int unsigned p = first; p < last_p; p++) begin
                case (op)
                    bpa_pkg::OP_FREE: begin
                        page_used[p] = 1'b0;
                        if (used_cnt > 0) used_cnt--;
                        if (free_cnt < MAP_PAGES) free_cnt++;
                    end
                    bpa_pkg::OP_USABLE: begin
                        page_used[p] = 1'b0;
                        if (free_cnt < MAP_PAGES) free_cnt++;
                    end
                    default: begin
                        page_used[p] = 1'b1;
                        if (free_cnt > 0) free_cnt--;
                        if (used_cnt < MAP_PAGES) used_cnt++;
                    end
                endcase
            end
        end
        res.free_total = CNT_W'(free_cnt);
        res.used_total = CNT_W'(used_cnt);
        return res;
    endfunction

    function automatic t_page_req page_req(input bpa_pkg::t_op op,
                                           input logic [ADDR_W-1:0] base,
                                           input logic [CNT_W-1:0] count);
        t_page_req r;
        r.op    = op;
        r.base  = base;
        r.count = count;
        return r;
    endfunction

    // byte address of a page with arbitrary offset bits below the page
    function automatic logic [ADDR_W-1:0] page_base(input int unsigned page);
        return {page[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'($urandom)};
    endfunction

    task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Request driver: holds an item until it is taken, idles at random otherwise.
    always @(posedge i_clk) begin : drive_requests
        t_page_req nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            foreach (page_used[p]) page_used[p] = 1'b1;
            free_cnt = 0;
            used_cnt = 0;
        end else begin
            if (s_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_page_op(s_tdata, s_tuser));
                req_accepted++;
            end
            if (!s_tvalid || s_axis_tready) begin
                // items 60..100 go without gaps
                if (pending_requests.size() != 0 &&
                    !((req_accepted < 60 || req_accepted > 100) &&
                      $urandom_range(0, 99) < 28)) begin
                    nxt = pending_requests.pop_front();
                    s_tdata  <= {{(IN_DATA_W - ADDR_W - CNT_W){1'b0}}, nxt.count, nxt.base};
                    s_tuser  <= nxt.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result checker and receiver back-pressure.
    always @(posedge i_clk) begin : collect_results
        t_page_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_address", want.addr, m_axis_tdata[ADDR_W-1:0]);
                    compare_field("fail", ADDR_W'(want.fail), ADDR_W'(m_axis_tuser));
                    compare_field("free_total", ADDR_W'(want.free_total),
                                  ADDR_W'(m_axis_tdata[ADDR_W +: CNT_W]));
                    compare_field("used_total", ADDR_W'(want.used_total),
                                  ADDR_W'(m_axis_tdata[ADDR_W + CNT_W +: CNT_W]));
                end
                results_seen++;
                // long hold-off so the core fills up and stalls its input
                if (results_seen == 30) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (results_seen >= 70 && results_seen <= 110) ||
                            ($urandom_range(0, 99) >= 28);
            end
        end
    end

    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned sel;
        int unsigned page;
        logic [CNT_W-1:0] cnt;

        // Directed: everything used after reset, so allocations fail first.
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'hFFFFFFF, 17'd1));
        // zero length
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h0000000, 17'd0));
        pending_requests.push_back(page_req(bpa_pkg::OP_USABLE, 28'h0000000, 17'd65536));
        // free saturates
        pending_requests.push_back(page_req(bpa_pkg::OP_USABLE, 28'h0000ABC, 17'd65536));
        // whole map
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h5555555, 17'd65536));
        // full miss
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h0000000, 17'd1));
        // last page
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, 28'hFFFFFFF, 17'd1));
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'hAAAAAAA, 17'd1));
        // past end
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, {16'd65530, 12'h123}, 17'd100));
        pending_requests.push_back(page_req(bpa_pkg::OP_RESERVE, 28'hFFFF000, 17'd65536));
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, 28'h0000FFF, 17'd16));
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h0000000, 17'd16));
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, {16'd5, 12'h000}, 17'd3));
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, {16'd20, 12'h800}, 17'd3));
        // skips short runs
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h0000000, 17'd4));
        pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, 28'h0000000, 17'd3));
        pending_requests.push_back(page_req(bpa_pkg::OP_USABLE, {16'd65520, 12'hFFF},
                                            17'd65535));
        // used saturates
        pending_requests.push_back(page_req(bpa_pkg::OP_RESERVE, 28'h0000000, 17'd65536));
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, 28'h0000000, 17'd65536));
        // used stays 0
        pending_requests.push_back(page_req(bpa_pkg::OP_FREE, 28'h0000000, 17'd65536));
        pending_requests.push_back(page_req(bpa_pkg::OP_RESERVE, 28'h0000000, 17'd65536));
        pending_requests.push_back(page_req(bpa_pkg::OP_USABLE, 28'h0000000,
                                            CNT_W'(POOL_PAGES)));

        // Random: mostly allocate/free traffic in the low pool, some noise up high.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            sel  = $urandom_range(0, 99);
            page = $urandom_range(0, POOL_PAGES - 1);
            if (sel < 45) begin
                cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(33, 512))
                                                  : CNT_W'($urandom_range(1, 32));
                pending_requests.push_back(page_req(bpa_pkg::OP_ALLOC, ADDR_W'($urandom),
                                                    cnt));
            end else if (sel < 65) begin
                pending_requests.push_back(page_req(bpa_pkg::OP_FREE, page_base(page),
                                                    CNT_W'($urandom_range(1, 64))));
            end else if (sel < 78) begin
                pending_requests.push_back(page_req(bpa_pkg::OP_USABLE, page_base(page),
                                                    CNT_W'($urandom_range(1, 128))));
            end else if (sel < 90) begin
                pending_requests.push_back(page_req(bpa_pkg::OP_RESERVE, page_base(page),
                                                    CNT_W'($urandom_range(1, 64))));
            end else begin
                // top pages only, so large counts are clipped at the map end
                pending_requests.push_back(page_req(bpa_pkg::t_op'($urandom_range(0, 3)),
                                                    page_base($urandom_range(61440, 65535)),
                                                    CNT_W'($urandom_range(1, 65536))));
            end
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_accepted != total_requests || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
